// ----- rtl/core/isr_pkg.sv -----
// ----------------------------------------------------------------------------
// isr_pkg
// shared types and constants for the interval set tracker
// ----------------------------------------------------------------------------
package isr_pkg;

  localparam int COORD_BITS = 16;
  localparam int CAPACITY   = 16;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 2);
  localparam int MODE_W     = 3;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [CNT_W-1:0]      count_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_FILL  = 3'd0,
    MODE_CLEAR = 3'd1,
    MODE_POINT = 3'd2,
    MODE_ANY   = 3'd3,
    MODE_ALL   = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TAIL,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic tail;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic skip;
    logic scan_done;
    logic out_busy;
  } status_t;

endpackage

// ----- rtl/core/isr_ctrl.sv -----
// ----------------------------------------------------------------------------
// isr_ctrl
// sequencer: load, walk the table, append tail, finish
// ----------------------------------------------------------------------------
module isr_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  isr_pkg::status_t status,
  output isr_pkg::cmd_t    cmd
);

  isr_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= isr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      isr_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = isr_pkg::ST_SCAN;
      end
      isr_pkg::ST_SCAN: begin
        if (status.skip) state_nxt = isr_pkg::ST_FINISH;
        else if (status.scan_done) state_nxt = isr_pkg::ST_TAIL;
      end
      isr_pkg::ST_TAIL: begin
        state_nxt = isr_pkg::ST_FINISH;
      end
      isr_pkg::ST_FINISH: begin
        if (!status.out_busy) state_nxt = isr_pkg::ST_IDLE;
      end
      default: state_nxt = isr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      isr_pkg::ST_IDLE: begin
        // nothing is taken while reset is held
        in_stall = !rst_n;
        cmd.load = in_valid && rst_n;
      end
      isr_pkg::ST_SCAN:   cmd.scan   = !status.skip && !status.scan_done;
      isr_pkg::ST_TAIL:   cmd.tail   = 1'b1;
      isr_pkg::ST_FINISH: cmd.finish = !status.out_busy;
      default: ;
    endcase
  end

endmodule

// ----- rtl/core/isr_dpath.sv -----
// ----------------------------------------------------------------------------
// isr_dpath
// double-banked interval table, one entry per scan step, result register
// ----------------------------------------------------------------------------
module isr_dpath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  isr_pkg::cmd_t                        cmd,
  output isr_pkg::status_t                     status,
  input  logic [isr_pkg::MODE_W-1:0]           in_mode,
  input  logic [isr_pkg::COORD_BITS-1:0]       in_low_bound,
  input  logic [isr_pkg::COORD_BITS-1:0]       in_high_bound,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_answer,
  output logic                                 out_full_res
);

  isr_pkg::coord_t st_r [2][isr_pkg::CAPACITY];
  isr_pkg::coord_t en_r [2][isr_pkg::CAPACITY];
  logic            bank_r;
  isr_pkg::count_t cnt_r, i_r, n_r;
  logic [isr_pkg::MODE_W-1:0] mode_r;
  isr_pkg::coord_t lo_r, hi_r, ms_r, me_r;
  logic            placed_r, split_r, ans_r;
  logic            out_valid_r, answer_r, full_r;

  isr_pkg::coord_t s, e, ws, we;
  logic            emit, adv, empty, wr, fits;

  assign s     = st_r[bank_r][i_r[isr_pkg::IDX_W-1:0]];
  assign e     = en_r[bank_r][i_r[isr_pkg::IDX_W-1:0]];
  assign empty = !(lo_r < hi_r);
  assign wr    = (mode_r == isr_pkg::MODE_FILL || mode_r == isr_pkg::MODE_CLEAR) && !empty;
  assign fits  = n_r <= isr_pkg::count_t'(isr_pkg::CAPACITY);

  always_comb begin
    status.scan_done = i_r == cnt_r;
    status.out_busy  = out_valid_r && out_stall;
    case (mode_r)
      isr_pkg::MODE_POINT:                        status.skip = 1'b0;
      isr_pkg::MODE_FILL, isr_pkg::MODE_CLEAR,
      isr_pkg::MODE_ANY, isr_pkg::MODE_ALL:       status.skip = empty;
      default:                                    status.skip = 1'b1;
    endcase
  end

  // per-entry decision
  always_comb begin
    emit = 1'b0;
    adv  = 1'b1;
    ws   = s;
    we   = e;
    if (cmd.tail) begin
      adv  = 1'b0;
      emit = (mode_r == isr_pkg::MODE_FILL) && !placed_r;
      ws   = ms_r;
      we   = me_r;
    end else if (mode_r == isr_pkg::MODE_FILL) begin
      if (e < lo_r) begin
        emit = 1'b1;
      end else if (s > hi_r) begin
        emit = 1'b1;
        if (!placed_r) begin
          ws  = ms_r;
          we  = me_r;
          adv = 1'b0;
        end
      end
    end else if (mode_r == isr_pkg::MODE_CLEAR) begin
      if (e <= lo_r || s >= hi_r) begin
        emit = 1'b1;
      end else if (s < lo_r && !split_r) begin
        emit = 1'b1;
        we   = lo_r;
        adv  = !(e > hi_r);
      end else if (e > hi_r) begin
        emit = 1'b1;
        ws   = hi_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r   <= in_mode;
      lo_r     <= in_low_bound;
      hi_r     <= in_high_bound;
      ms_r     <= in_low_bound;
      me_r     <= in_high_bound;
      i_r      <= '0;
      n_r      <= '0;
      placed_r <= 1'b0;
      split_r  <= 1'b0;
      ans_r    <= 1'b0;
    end else if (cmd.scan || cmd.tail) begin
      if (emit) begin
        n_r <= n_r + 1'b1;
        if (n_r < isr_pkg::count_t'(isr_pkg::CAPACITY)) begin
          st_r[~bank_r][n_r[isr_pkg::IDX_W-1:0]] <= ws;
          en_r[~bank_r][n_r[isr_pkg::IDX_W-1:0]] <= we;
        end
      end
      if (adv) i_r <= i_r + 1'b1;
      if (cmd.scan) begin
        case (mode_r)
          isr_pkg::MODE_FILL: begin
            if (!(e < lo_r) && s > hi_r) begin
              placed_r <= 1'b1;
            end else if (!(e < lo_r)) begin
              if (s < ms_r) ms_r <= s;
              if (e > me_r) me_r <= e;
            end
          end
          isr_pkg::MODE_CLEAR: split_r <= !adv;
          isr_pkg::MODE_POINT: if (s <= lo_r && lo_r < e) ans_r <= 1'b1;
          isr_pkg::MODE_ANY:   if (s < hi_r && e > lo_r) ans_r <= 1'b1;
          isr_pkg::MODE_ALL:   if (s <= lo_r && e >= hi_r) ans_r <= 1'b1;
          default: ;
        endcase
      end
    end
  end

  // commit by bank swap, result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
        if (wr && fits) begin
          bank_r <= ~bank_r;
          cnt_r  <= n_r;
        end
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      answer_r <= ans_r && !status.skip;
      full_r   <= wr && !fits;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_answer   = answer_r;
  assign out_full_res = full_r;

endmodule

// ----- rtl/core/interval_set_tracker_top.sv -----
// ----------------------------------------------------------------------------
// interval_set_tracker_top
// sorted table of disjoint half-open intervals with fill, clear and queries
// ----------------------------------------------------------------------------
//  channel  direction  handshake           payload
//  in       input      in_valid/in_stall   in_mode, in_low_bound, in_high_bound
//  out      output     out_valid/out_stall out_answer, out_full_res
//
//  one word at a time; the table walk touches one stored entry per cycle
//  a word is loaded, then the walk visits each stored entry, holding on the
//  entry where a fill places its range or a clear splits it, then the tail
//  and finish steps follow; empty ranges and unused modes skip walk and tail
//  reset leaves the table empty, no clearing pass
//  in_stall is high while a word is in flight; a waiting result holds the
//  finish step only, the next word can be taken before it is delivered
// ----------------------------------------------------------------------------
module interval_set_tracker_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [isr_pkg::MODE_W-1:0]     in_mode,
  input  logic [isr_pkg::COORD_BITS-1:0] in_low_bound,
  input  logic [isr_pkg::COORD_BITS-1:0] in_high_bound,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_answer,
  output logic                           out_full_res
);

  // command and status between sequencer and datapath
  isr_pkg::cmd_t    cmd;
  isr_pkg::status_t status;

  isr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  isr_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .in_mode       (in_mode),
    .in_low_bound  (in_low_bound),
    .in_high_bound (in_high_bound),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_answer    (out_answer),
    .out_full_res  (out_full_res)
  );

  // an accepted word keeps the input side stalled next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while busy");

  // finishing always presents a result
  a_finish_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid)
    else $error("finish without result");

  // a full flag never comes with a query answer
  a_full_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_full_res && out_answer))
    else $error("full flag with answer");

  // only one command at a time
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.scan, cmd.tail, cmd.finish}))
    else $error("overlapping commands");

endmodule

// ----- test/interval_set_tracker_top_tb.sv -----
// ----------------------------------------------------------------------------
// interval_set_tracker_top_tb
// checks the interval table against its own sorted-table predictor; directed
// fill, clear and query words first, then random words biased towards small
// windows at both ends of the space so merges, splits and overflow happen often
// ----------------------------------------------------------------------------
module interval_set_tracker_top_tb;

  localparam int N_RANDOM   = 1800;
  localparam int CYCLE_CAP  = 600000;

  typedef struct packed {
    logic [isr_pkg::MODE_W-1:0] mode;
    isr_pkg::coord_t            lo;
    isr_pkg::coord_t            hi;
  } op_word_t;

  typedef struct packed {
    logic answer;
    logic full;
  } reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [isr_pkg::MODE_W-1:0] in_mode = '0;
  isr_pkg::coord_t in_low_bound = '0;
  isr_pkg::coord_t in_high_bound = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_answer;
  logic out_full_res;

  interval_set_tracker_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_mode(in_mode), .in_low_bound(in_low_bound), .in_high_bound(in_high_bound),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_answer(out_answer), .out_full_res(out_full_res)
  );

  // predictor copy of the table, sorted by start
  logic [16:0] tbl_start [isr_pkg::CAPACITY];
  logic [16:0] tbl_end   [isr_pkg::CAPACITY];
  int          tbl_count;

  op_word_t pending_words[$];
  reply_t   expected_replies[$];

  int  n_errors = 0;
  int  n_checked = 0;
  int  n_full_seen = 0;
  int  n_hits = 0;
  int  cycle = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  int  hold_cycles = 0;
  bit  pause_sender = 1'b0;
  bit  long_hold_go = 1'b0;
  bit  long_hold_done = 1'b0;

  // apply one word to the predictor and return the reply it should give
  function automatic reply_t predict_reply(op_word_t w);
    logic [16:0] ns [isr_pkg::CAPACITY+1];
    logic [16:0] ne [isr_pkg::CAPACITY+1];
    logic [16:0] lo, hi, ms, me, s, e;
    int n;
    bit placed;
    reply_t r;
    r = '0;
    lo = {1'b0, w.lo};
    hi = {1'b0, w.hi};
    n = 0;
    placed = 0;
    ms = lo;
    me = hi;
    case (w.mode)
      isr_pkg::MODE_FILL, isr_pkg::MODE_CLEAR: begin
        if (lo < hi) begin
          for (int i = 0; i < tbl_count; i++) begin
            s = tbl_start[i];
            e = tbl_end[i];
            if (w.mode == isr_pkg::MODE_FILL) begin
              if (e < lo) begin
                ns[n] = s; ne[n] = e; n++;
              end else if (s > hi) begin
                if (!placed) begin
                  ns[n] = ms; ne[n] = me; n++; placed = 1;
                end
                ns[n] = s; ne[n] = e; n++;
              end else begin
                if (s < ms) ms = s;
                if (e > me) me = e;
              end
            end else if (e <= lo || s >= hi) begin
              ns[n] = s; ne[n] = e; n++;
            end else begin
              if (s < lo) begin
                ns[n] = s; ne[n] = lo; n++;
              end
              if (e > hi && n <= isr_pkg::CAPACITY) begin
                ns[n] = hi; ne[n] = e; n++;
              end else if (e > hi) begin
                n++;
              end
            end
          end
          if (w.mode == isr_pkg::MODE_FILL && !placed) begin
            ns[n] = ms; ne[n] = me; n++;
          end
          if (n > isr_pkg::CAPACITY) begin
            r.full = 1'b1;
          end else begin
            for (int i = 0; i < n; i++) begin
              tbl_start[i] = ns[i];
              tbl_end[i] = ne[i];
            end
            tbl_count = n;
          end
        end
      end
      isr_pkg::MODE_POINT:
        for (int i = 0; i < tbl_count; i++)
          if (tbl_start[i] <= lo && lo < tbl_end[i]) r.answer = 1'b1;
      isr_pkg::MODE_ANY:
        if (lo < hi)
          for (int i = 0; i < tbl_count; i++)
            if (tbl_start[i] < hi && tbl_end[i] > lo) r.answer = 1'b1;
      isr_pkg::MODE_ALL:
        if (lo < hi)
          for (int i = 0; i < tbl_count; i++)
            if (tbl_start[i] <= lo && tbl_end[i] >= hi) r.answer = 1'b1;
      default: ;
    endcase
    return r;
  endfunction

  function automatic op_word_t make_word(logic [isr_pkg::MODE_W-1:0] m, int lo, int hi);
    op_word_t w;
    w.mode = m;
    w.lo = isr_pkg::coord_t'(lo);
    w.hi = isr_pkg::coord_t'(hi);
    return w;
  endfunction

  // random word: mostly fills, clears and queries inside narrow windows
  function automatic op_word_t random_word();
    op_word_t w;
    int span, base, a, b;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 30)      w.mode = isr_pkg::MODE_FILL;
    else if (pick < 55) w.mode = isr_pkg::MODE_CLEAR;
    else if (pick < 68) w.mode = isr_pkg::MODE_POINT;
    else if (pick < 81) w.mode = isr_pkg::MODE_ANY;
    else if (pick < 94) w.mode = isr_pkg::MODE_ALL;
    else                w.mode = isr_pkg::MODE_W'($urandom_range(5, 7));
    if ($urandom_range(0, 9) == 0) begin
      // full range of the coordinate space so every bit toggles
      w.lo = isr_pkg::coord_t'($urandom);
      w.hi = isr_pkg::coord_t'($urandom);
    end else begin
      span = ($urandom_range(0, 3) == 0) ? 4096 : 200;
      base = ($urandom_range(0, 1) == 0) ? 0 : 65535 - span;
      a = base + $urandom_range(0, span);
      b = a + $urandom_range(0, 12);
      if (b > 65535) b = 65535;
      if ($urandom_range(0, 15) == 0) begin
        w.lo = isr_pkg::coord_t'(b); w.hi = isr_pkg::coord_t'(a);
      end else begin
        w.lo = isr_pkg::coord_t'(a); w.hi = isr_pkg::coord_t'(b);
      end
    end
    return w;
  endfunction

  task automatic report_mismatch(string what, logic got, logic want);
    n_errors++;
    $display("mismatch at cycle %0d: %s got %0b expected %0b", cycle, what, got, want);
  endtask

  // clock
  initial begin
    forever #2 clk = ~clk;
  end

  // cycle counter and run limit
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d replies outstanding", cycle,
               expected_replies.size());
      $display("interval_set_tracker_top_tb: FAIL");
      $finish;
    end
  end

  // driver: a word leaves the queue when accepted; valid stays up across words
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_replies.push_back(predict_reply({in_mode, in_low_bound, in_high_bound}));
        void'(pending_words.pop_front());
      end
      if ((!in_valid || !in_stall)) begin
        if (pending_words.size() > 0 && !pause_sender
            && $urandom_range(0, 99) >= send_idle_pct) begin
          op_word_t w;
          w = pending_words[0];
          in_valid <= 1'b1;
          in_mode <= w.mode;
          in_low_bound <= w.lo;
          in_high_bound <= w.hi;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall, with one long hold-off counted here
  always @(posedge clk) begin
    if (long_hold_go && !long_hold_done) begin
      long_hold_done <= 1'b1;
      hold_cycles <= 400;
      out_stall <= 1'b1;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // monitor: compare each delivered reply with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_replies.size() == 0) begin
        report_mismatch("reply with none expected, answer", out_answer, 1'b0);
      end else begin
        reply_t want;
        want = expected_replies.pop_front();
        n_checked++;
        if (out_full_res) n_full_seen++;
        if (out_answer) n_hits++;
        if (out_answer !== want.answer) report_mismatch("answer", out_answer, want.answer);
        if (out_full_res !== want.full) report_mismatch("full_res", out_full_res, want.full);
      end
    end
  end

  task automatic wait_drained();
    while (pending_words.size() != 0 || expected_replies.size() != 0 || in_valid)
      @(posedge clk);
    repeat (2 * isr_pkg::CAPACITY + 10) @(posedge clk);
  endtask

  initial begin
    int per_phase;
    tbl_count = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, every mode, empty ranges, touching merges, splits
    pending_words.push_back(make_word(isr_pkg::MODE_POINT, 0, 0));
    pending_words.push_back(make_word(isr_pkg::MODE_ANY, 0, 65535));
    pending_words.push_back(make_word(isr_pkg::MODE_FILL, 0, 65535));
    pending_words.push_back(make_word(isr_pkg::MODE_ALL, 0, 65535));
    pending_words.push_back(make_word(isr_pkg::MODE_POINT, 65535, 0));
    pending_words.push_back(make_word(isr_pkg::MODE_CLEAR, 100, 200));
    pending_words.push_back(make_word(isr_pkg::MODE_POINT, 100, 0));
    pending_words.push_back(make_word(isr_pkg::MODE_POINT, 99, 0));
    pending_words.push_back(make_word(isr_pkg::MODE_ANY, 150, 150));
    pending_words.push_back(make_word(isr_pkg::MODE_ALL, 200, 150));
    pending_words.push_back(make_word(isr_pkg::MODE_FILL, 200, 100));
    pending_words.push_back(make_word(isr_pkg::MODE_CLEAR, 0, 65535));
    pending_words.push_back(make_word(isr_pkg::MODE_FILL, 10, 20));
    pending_words.push_back(make_word(isr_pkg::MODE_FILL, 20, 30));
    pending_words.push_back(make_word(isr_pkg::MODE_FILL, 5, 10));
    pending_words.push_back(make_word(isr_pkg::MODE_ALL, 5, 30));
    pending_words.push_back(make_word(isr_pkg::MODE_CLEAR, 12, 14));
    pending_words.push_back(make_word(isr_pkg::MODE_ANY, 12, 14));
    pending_words.push_back(make_word(isr_pkg::MODE_ANY, 11, 13));
    // unused mode codes
    pending_words.push_back(make_word(5, 1, 2));
    pending_words.push_back(make_word(7, 65535, 65535));
    // many separate fills until the table overflows
    for (int i = 0; i < 17; i++)
      pending_words.push_back(make_word(isr_pkg::MODE_FILL, 1000 + 4 * i, 1002 + 4 * i));
    pending_words.push_back(make_word(isr_pkg::MODE_CLEAR, 1021, 1022));
    wait_drained();

    // random phases: no idling, sender idle, receiver stalling, both
    per_phase = N_RANDOM / 4;
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 68 : (ph == 3) ? 32 : 0;
      recv_stall_pct = (ph == 2) ? 68 : (ph == 3) ? 32 : 0;
      for (int k = 0; k < per_phase; k++) begin
        pending_words.push_back(random_word());
        if (k == per_phase / 2 && ph == 0) begin
          // long receiver hold-off while the sender keeps offering words
          long_hold_go = 1'b1;
        end
        if (k == per_phase / 2 && ph == 2) begin
          // sender pause until every reply is back
          while (pending_words.size() != 0) @(posedge clk);
          pause_sender = 1'b1;
          while (expected_replies.size() != 0 || in_valid) @(posedge clk);
          pause_sender = 1'b0;
        end
        if (pending_words.size() > 8) @(posedge clk);
      end
    end
    wait_drained();

    $display("covered %0d replies, %0d with table full, %0d query hits", n_checked,
             n_full_seen, n_hits);
    $display("idle and stall phases run, including a long receiver hold-off");
    if (n_errors == 0) begin
      $display("interval_set_tracker_top_tb: PASS");
    end else begin
      $display("interval_set_tracker_top_tb: FAIL");
    end
    $finish;
  end

endmodule
